/* rtl/core/sip_stream_deframer_core_defines.svh */
// assertion macros for the sip stream deframer core
// no dependencies; expects clk and arst_n in the including module
`ifndef SIP_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define SIP_STREAM_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define SIPD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sipd check failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define SIPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sipd check failed: next-cycle implication");

`else

`define SIPD_ASSERT_IMPL(lbl, ante, cons)
`define SIPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/sipd_pkg.sv */
// shared types, character codes and name table for the sip stream deframer
// no dependencies
`timescale 1ns / 1ps

package sipd_pkg;

	// default width of the body length counter
	localparam int LEN_BITS_DEF = 32;

	// characters of interest
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CTL_HI = 8'h0D;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LOW_L = 8'h6C;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	// long header name length and position limit
	localparam logic [3:0] LONG_NAME_LEN = 4'd14;
	localparam logic [3:0] NAME_POS_MAX  = 4'd15;

	// terminator progress codes for cr lf cr lf
	localparam logic [1:0] TERM_NONE  = 2'd0;
	localparam logic [1:0] TERM_CR    = 2'd1;
	localparam logic [1:0] TERM_CRLF  = 2'd2;
	localparam logic [1:0] TERM_CRLFCR = 2'd3;

	// candidate mask bits
	localparam logic [1:0] CAND_ALL  = 2'b11;
	localparam logic [1:0] CAND_NONE = 2'b00;

	// position within one header line
	typedef enum logic [2:0] {
		STG_LEAD,
		STG_NAME,
		STG_TAIL,
		STG_VLEAD,
		STG_SIGN,
		STG_DIGITS,
		STG_SKIP
	} line_stage_t;

	// control from the frame logic to the header parser
	typedef struct packed {
		logic step;
		logic clear;
	} hdr_ctl_t;

	// lower-case characters of the long length header name
	function automatic logic [7:0] long_name_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h63; // c
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h6C; // l
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* rtl/core/sipd_hdr_parse.sv */
// header line parser: finds the first length header and reads its value
// depends on sipd_pkg
`timescale 1ns / 1ps

module sipd_hdr_parse import sipd_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_in,
	input  hdr_ctl_t            ctl,
	output logic                len_decided,
	output logic [LEN_BITS-1:0] len_value
);

	line_stage_t         stg_q, stg_d;
	logic [3:0]          pos_q, pos_d;
	logic [1:0]          cand_q, cand_d;
	logic                dec_q, dec_d;
	logic [LEN_BITS-1:0] val_q, val_d;

	logic [7:0]          lc;
	logic                is_ws, is_digit, hit;
	logic [1:0]          cand_t;
	logic [LEN_BITS+3:0] val_ext, val_next;
	logic [3:0]          digit;

	// character classes and the decimal step
	always_comb begin
		lc       = (byte_in >= CHAR_UP_A && byte_in <= CHAR_UP_Z) ? (byte_in | CASE_BIT) : byte_in;
		is_ws    = (byte_in inside {CHAR_SPACE, [CHAR_TAB:CHAR_CTL_HI]});
		is_digit = (byte_in inside {[CHAR_ZERO:CHAR_NINE]});
		digit    = 4'(byte_in - CHAR_ZERO);
		val_ext  = {4'b0, val_q};
		val_next = (val_ext << 3) + (val_ext << 1) + {{LEN_BITS{1'b0}}, digit};
		hit      = (cand_q[0] && pos_q == LONG_NAME_LEN) || (cand_q[1] && pos_q == 4'd1);
	end

	// next state of the line walker
	always_comb begin
		stg_d  = stg_q;
		pos_d  = pos_q;
		cand_d = cand_q;
		dec_d  = dec_q;
		val_d  = val_q;
		cand_t = cand_q;
		if (ctl.clear) begin
			stg_d  = STG_LEAD;
			pos_d  = '0;
			cand_d = CAND_ALL;
			dec_d  = 1'b0;
			val_d  = '0;
		end else if (ctl.step) begin
			if (byte_in == CHAR_LF) begin
				stg_d  = STG_LEAD;
				pos_d  = '0;
				cand_d = CAND_ALL;
			end else begin
				case (stg_q)
					STG_LEAD, STG_NAME, STG_TAIL: begin
						if (byte_in == CHAR_COLON) begin
							if (hit && !dec_q) begin
								dec_d = 1'b1;
								val_d = '0;
								stg_d = STG_VLEAD;
							end else begin
								stg_d = STG_SKIP;
							end
						end else if (is_ws) begin
							if (stg_q == STG_NAME)
								stg_d = STG_TAIL;
						end else begin
							// inner whitespace kills both names
							if (stg_q == STG_TAIL)
								cand_t = CAND_NONE;
							if (pos_q >= LONG_NAME_LEN || lc != long_name_char(pos_q))
								cand_t[0] = 1'b0;
							if (pos_q != 4'd0 || lc != CHAR_LOW_L)
								cand_t[1] = 1'b0;
							cand_d = cand_t;
							if (pos_q < NAME_POS_MAX)
								pos_d = pos_q + 4'd1;
							stg_d = STG_NAME;
						end
					end
					STG_VLEAD, STG_SIGN, STG_DIGITS: begin
						if (is_digit) begin
							// value past the counter range reads as zero
							if (|val_next[LEN_BITS+3:LEN_BITS]) begin
								val_d = '0;
								stg_d = STG_SKIP;
							end else begin
								val_d = val_next[LEN_BITS-1:0];
								stg_d = STG_DIGITS;
							end
						end else if (stg_q == STG_VLEAD && is_ws) begin
							stg_d = STG_VLEAD;
						end else if (stg_q == STG_VLEAD && byte_in == CHAR_PLUS) begin
							stg_d = STG_SIGN;
						end else begin
							if (stg_q == STG_VLEAD && byte_in == CHAR_MINUS)
								val_d = '0;
							stg_d = STG_SKIP;
						end
					end
					default: begin
						stg_d = stg_q;
					end
				endcase
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q  <= STG_LEAD;
			pos_q  <= '0;
			cand_q <= CAND_ALL;
			dec_q  <= 1'b0;
			val_q  <= '0;
		end else begin
			stg_q  <= stg_d;
			pos_q  <= pos_d;
			cand_q <= cand_d;
			dec_q  <= dec_d;
			val_q  <= val_d;
		end
	end

	assign len_decided = dec_q;
	assign len_value   = val_q;

endmodule

/* rtl/core/sip_stream_deframer_core.sv */
// top level of the sip stream deframer: handshake stages, terminator match, body count
// depends on sipd_pkg, sipd_hdr_parse and sip_stream_deframer_core_defines.svh
`timescale 1ns / 1ps

`include "sip_stream_deframer_core_defines.svh"

// Byte stream deframer for content-length framed messages. Every byte taken on the
// item channel comes back on the result channel unchanged, tagged as header or body,
// with end_of_message on the last byte of each message (the final LF of the header
// when the length is zero, otherwise the last body byte). One beat is accepted per
// clock cycle while item_stall is low; each beat passes through the input register and
// then the result register before it is presented on the result side. The per-byte
// state update (line parse, terminator match, body count) is short combinational logic
// between the input register and the result register. A stall on the result side holds
// both stages and then the input. The body counter is LEN_BITS wide; a declared length
// that does not fit reads as 0.
module sip_stream_deframer_core import sipd_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] in_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       is_body,
	output logic       end_of_message
);

	logic                vld_s1, vld_s2;
	logic [7:0]          byte_s1, byte_s2;
	logic                body_s2, eom_s2;
	logic                load_s2, accept;

	logic                body_q, body_d;
	logic [1:0]          term_q, term_d;
	logic [LEN_BITS-1:0] rem_q, rem_d, rem_load;
	logic                done, eom;

	hdr_ctl_t            hctl;
	logic                len_decided;
	logic [LEN_BITS-1:0] len_value;

	// beat flow between the two stages
	assign load_s2    = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall = vld_s1 && !load_s2;
	assign accept     = item_valid && !item_stall;

	// header line parser
	sipd_hdr_parse #(
		.LEN_BITS(LEN_BITS)
	) u_hdr (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_s1),
		.ctl        (hctl),
		.len_decided(len_decided),
		.len_value  (len_value)
	);

	// terminator match and body count
	always_comb begin
		body_d   = body_q;
		term_d   = term_q;
		rem_d    = rem_q;
		done     = 1'b0;
		eom      = 1'b0;
		rem_load = len_decided ? len_value : '0;
		if (body_q) begin
			rem_d = rem_q - 1'b1;
			if (rem_d == '0) begin
				eom    = 1'b1;
				body_d = 1'b0;
				term_d = TERM_NONE;
			end
		end else begin
			if (byte_s1 == CHAR_CR) begin
				term_d = (term_q == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
			end else if (byte_s1 == CHAR_LF && (term_q == TERM_CR || term_q == TERM_CRLFCR)) begin
				done   = (term_q == TERM_CRLFCR);
				term_d = TERM_CRLF;
			end else begin
				term_d = TERM_NONE;
			end
			if (done) begin
				term_d = TERM_NONE;
				rem_d  = rem_load;
				if (rem_load == '0)
					eom = 1'b1;
				else
					body_d = 1'b1;
			end
		end
		hctl.step  = load_s2 && !body_q;
		hctl.clear = load_s2 && (done || (body_q && eom));
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q <= 1'b0;
			term_q <= TERM_NONE;
			rem_q  <= '0;
		end else if (load_s2) begin
			body_q <= body_d;
			term_q <= term_d;
			rem_q  <= rem_d;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (accept)
			vld_s1 <= 1'b1;
		else if (load_s2)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= in_byte;
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (load_s2)
			vld_s2 <= 1'b1;
		else if (!result_stall)
			vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			byte_s2 <= byte_s1;
			body_s2 <= body_q;
			eom_s2  <= eom;
		end
	end

	assign result_valid   = vld_s2;
	assign out_byte       = byte_s2;
	assign is_body        = body_s2;
	assign end_of_message = eom_s2;

	// checks on the frame logic
	`SIPD_ASSERT_IMPL(a_stall_needs_beat, item_stall, vld_s1)
	`SIPD_ASSERT_IMPL(a_body_count_live, body_q, rem_q != '0)
	`SIPD_ASSERT_IMPL(a_body_term_idle, body_q, term_q == TERM_NONE)
	`SIPD_ASSERT_IMPL(a_hdr_eom_on_lf, vld_s2 && eom_s2 && !body_s2, byte_s2 == CHAR_LF)
	`SIPD_ASSERT_NEXT(a_held_result, vld_s2 && result_stall, vld_s2 && $stable(byte_s2))

endmodule
